// ===== src/kle_pkg.sv =====
// ----------------------------------------------------------------------------
// kle_pkg: shared types and constants of the k-means engine
// Field formats, cell command and status words, scan token and state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kle_pkg;

	localparam int CLUSTERS   = 8;
	localparam int FEATURES   = 4;
	localparam int COUNT_BITS = 16;

	localparam int CL_W    = $clog2(CLUSTERS);
	localparam int FT_W    = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int VAL_W   = 16;
	localparam int SUM_W   = VAL_W + COUNT_BITS + 1;
	localparam int DIST_W  = 36;
	localparam int SQE_W   = 2 * VAL_W;
	localparam int ACC_W   = SQE_W + FT_W;
	localparam int ROOT_W  = (ACC_W + 1) / 2;
	localparam int MOVE_W  = 22;
	localparam int PASS_W  = 16;
	localparam int CFG_W   = 36;
	localparam int DIV_CW  = $clog2(SUM_W + 1);
	localparam int ROOT_CW = $clog2(ROOT_W + 1);

	localparam logic [PASS_W-1:0] MAX_PASSES_RST = PASS_W'(100);

	typedef enum logic [1:0] {
		OP_LOAD     = 2'd0,
		OP_TRAIN    = 2'd1,
		OP_PASS     = 2'd2,
		OP_CLASSIFY = 2'd3
	} op_t;

	localparam logic CFG_MAX_PASSES = 1'b0;
	localparam logic CFG_REJECT     = 1'b1;

	typedef struct packed {
		op_t                opcode;
		logic [2:0]         cluster_sel;
		logic [1:0]         feature_sel;
		logic signed [15:0] value;
		logic               point_last;
	} in_word_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  nearest;
		logic        matched;
		logic [21:0] movement;
		logic [15:0] pass_number;
		logic        finished;
	} out_word_t;

	typedef struct packed {
		logic             index;
		logic [CFG_W-1:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic                           elem;
		logic                           cent_wr;
		logic                           add_pt;
		logic                           clr_pt;
		logic                           clr_acc;
		logic [CL_W-1:0]                cl;
		logic [FT_W-1:0]                ft;
		logic signed [VAL_W-1:0]        val;
		logic [FEATURES-1:0][VAL_W-1:0] pt;
	} cell_cmd_t;

	typedef struct packed {
		logic [FEATURES-1:0][VAL_W-1:0] cent;
		logic [FEATURES-1:0][SUM_W-1:0] sum;
		logic [COUNT_BITS-1:0]          cnt;
	} cell_stat_t;

	typedef struct packed {
		logic              valid;
		logic [DIST_W:0]   dval;
		logic [CL_W-1:0]   idx;
	} scan_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELEM,
		ST_SCAN_GO,
		ST_SCAN,
		ST_RESOLVE,
		ST_PASS_CL,
		ST_DIV_GO,
		ST_DIV,
		ST_DIFF,
		ST_ACC,
		ST_ROOT_GO,
		ST_ROOT,
		ST_REPORT
	} st_t;

endpackage

`default_nettype wire

// ===== src/kle_if.sv =====
// ----------------------------------------------------------------------------
// kle_if: valid/ready channels of the k-means engine
// Request, response and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface kle_in_if;
	logic              valid;
	logic              ready;
	kle_pkg::in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kle_out_if;
	logic               valid;
	logic               ready;
	kle_pkg::out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kle_cfg_if;
	logic               valid;
	logic               ready;
	kle_pkg::cfg_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/kle_cell.sv =====
// ----------------------------------------------------------------------------
// kle_cell: one cluster of the cell row
// Holds centroid, sums, member count and partial distance of one cluster;
// passes the running nearest-cluster token on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [kle_pkg::CL_W-1:0] cl_idx,
	input  wire kle_pkg::cell_cmd_t    cmd,
	input  wire kle_pkg::scan_t        scan_i,
	output kle_pkg::scan_t             scan_o,
	output kle_pkg::cell_stat_t        stat
);

	logic [kle_pkg::FEATURES-1:0][kle_pkg::VAL_W-1:0] cent_q;
	logic [kle_pkg::FEATURES-1:0][kle_pkg::SUM_W-1:0] sum_q;
	logic [kle_pkg::COUNT_BITS-1:0]                   cnt_q;
	logic [kle_pkg::DIST_W-1:0]                       pdist_q;
	logic [kle_pkg::SQE_W-1:0]                        sq_s1;
	logic                                             sq_v_s1;
	kle_pkg::scan_t                                   scan_q;

	logic signed [kle_pkg::VAL_W:0]     diff;
	logic signed [2*kle_pkg::VAL_W+1:0] prod;
	logic [kle_pkg::DIST_W:0]           psum;
	logic                               hit;

	assign diff = $signed({cmd.val[kle_pkg::VAL_W-1], cmd.val})
		- $signed({cent_q[cmd.ft][kle_pkg::VAL_W-1], cent_q[cmd.ft]});
	assign prod = diff * diff;
	assign psum = {1'b0, pdist_q} + (kle_pkg::DIST_W + 1)'(sq_s1);
	assign hit  = (cmd.cl == cl_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cent_q  <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			pdist_q <= '0;
			sq_s1   <= '0;
			sq_v_s1 <= 1'b0;
			scan_q  <= '0;
		end else begin
			sq_v_s1 <= cmd.elem;
			if (cmd.elem) begin
				sq_s1 <= prod[kle_pkg::SQE_W-1:0];
			end
			// distance saturates at all ones
			if (cmd.clr_pt) begin
				pdist_q <= '0;
			end else if (sq_v_s1) begin
				pdist_q <= psum[kle_pkg::DIST_W] ? '1 : psum[kle_pkg::DIST_W-1:0];
			end
			if (cmd.cent_wr && hit) begin
				cent_q[cmd.ft] <= cmd.val;
			end
			if (cmd.clr_acc) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (cmd.add_pt && hit && (cnt_q != '1)) begin
				for (int f = 0; f < kle_pkg::FEATURES; f++) begin
					sum_q[f] <= sum_q[f] + kle_pkg::SUM_W'($signed(cmd.pt[f]));
				end
				cnt_q <= cnt_q + 1'b1;
			end
			// strict compare keeps the lower index on a tie
			scan_q.valid <= scan_i.valid;
			if ({1'b0, pdist_q} < scan_i.dval) begin
				scan_q.dval <= {1'b0, pdist_q};
				scan_q.idx  <= cl_idx;
			end else begin
				scan_q.dval <= scan_i.dval;
				scan_q.idx  <= scan_i.idx;
			end
		end
	end

	assign scan_o    = scan_q;
	assign stat.cent = cent_q;
	assign stat.sum  = sum_q;
	assign stat.cnt  = cnt_q;

endmodule

`default_nettype wire

// ===== src/kle_div.sv =====
// ----------------------------------------------------------------------------
// kle_div: iterative signed sum by member count divider
// Restoring, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [kle_pkg::SUM_W-1:0]     dividend,
	input  wire logic [kle_pkg::COUNT_BITS-1:0] divisor,
	output logic                               done,
	output logic [kle_pkg::VAL_W-1:0]          quotient
);

	logic [kle_pkg::SUM_W-1:0]      quo_q;
	logic [kle_pkg::COUNT_BITS-1:0] rem_q;
	logic [kle_pkg::COUNT_BITS-1:0] den_q;
	logic                           neg_q;
	logic                           busy_q;
	logic                           done_q;
	logic [kle_pkg::DIV_CW-1:0]     cnt_q;

	logic [kle_pkg::COUNT_BITS:0] trial;
	logic [kle_pkg::SUM_W-1:0]    mag;
	logic [kle_pkg::SUM_W-1:0]    sgn_quo;

	assign trial   = {rem_q, quo_q[kle_pkg::SUM_W-1]};
	assign mag     = dividend[kle_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
	assign sgn_quo = neg_q ? (~quo_q + 1'b1) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= kle_pkg::DIV_CW'(kle_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kle_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= divisor;
			neg_q <= dividend[kle_pkg::SUM_W-1];
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= kle_pkg::COUNT_BITS'(trial - {1'b0, den_q});
				quo_q <= {quo_q[kle_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[kle_pkg::COUNT_BITS-1:0];
				quo_q <= {quo_q[kle_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = sgn_quo[kle_pkg::VAL_W-1:0];

endmodule

`default_nettype wire

// ===== src/kle_isqrt.sv =====
// ----------------------------------------------------------------------------
// kle_isqrt: iterative integer square root
// Digit by digit, one root bit per cycle, floor result.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kle_pkg::ACC_W-1:0]   x,
	output logic                             done,
	output logic [kle_pkg::ROOT_W-1:0]       root
);

	logic [2*kle_pkg::ROOT_W-1:0] xs_q;
	logic [kle_pkg::ROOT_W:0]     rem_q;
	logic [kle_pkg::ROOT_W-1:0]   root_q;
	logic                         busy_q;
	logic                         done_q;
	logic [kle_pkg::ROOT_CW-1:0]  cnt_q;

	logic [kle_pkg::ROOT_W+2:0] r2;
	logic [kle_pkg::ROOT_W+2:0] trial;

	assign r2    = {rem_q, xs_q[2*kle_pkg::ROOT_W-1 -: 2]};
	assign trial = (kle_pkg::ROOT_W + 3)'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= kle_pkg::ROOT_CW'(kle_pkg::ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kle_pkg::ROOT_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			xs_q   <= (2*kle_pkg::ROOT_W)'(x);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			xs_q <= {xs_q[2*kle_pkg::ROOT_W-3:0], 2'b00};
			if (r2 >= trial) begin
				rem_q  <= (kle_pkg::ROOT_W + 1)'(r2 - trial);
				root_q <= {root_q[kle_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= r2[kle_pkg::ROOT_W:0];
				root_q <= {root_q[kle_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

// ===== src/kmeans_lloyd_engine_unit.sv =====
// Element word: IDLE then ELEM. Point end adds SCAN_GO, SCAN (token runs the cell row) and RESOLVE.
// End of pass: a PASS_CL step per cluster, per non-empty cluster DIV_GO, DIV, DIFF, ACC per feature,
// then ROOT_GO, ROOT; then REPORT. The divider and root unit are bit-serial. One word in work at a time.
// Results wait in an output register; a new word is taken while one waits.
// Async active-low reset clears centroids, sums, counts, distances and the pass count.
// ----------------------------------------------------------------------------
// kmeans_lloyd_engine_unit: k-means training and classification engine
// Sequencer around a row of cluster cells, a serial divider and a root unit.
// ----------------------------------------------------------------------------
`default_nettype none

module kmeans_lloyd_engine_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	kle_in_if.sink     req,
	kle_out_if.source  rsp,
	kle_cfg_if.sink    cfg
);

	kle_pkg::st_t state_q, state_d;

	logic [kle_pkg::PASS_W-1:0]  max_passes_q;
	logic [kle_pkg::DIST_W-1:0]  reject_q;
	logic [kle_pkg::PASS_W-1:0]  pass_q;
	logic [kle_pkg::FEATURES-1:0][kle_pkg::VAL_W-1:0] buf_q;
	kle_pkg::op_t                op_q;
	logic                        last_q;
	logic [kle_pkg::CL_W-1:0]    best_idx_q;
	logic [kle_pkg::DIST_W-1:0]  best_dist_q;
	logic [kle_pkg::CL_W-1:0]    pc_q;
	logic [kle_pkg::FT_W-1:0]    pf_q;
	logic [kle_pkg::VAL_W-1:0]   nv_q;
	logic [kle_pkg::SQE_W-1:0]   sqd_s1;
	logic [kle_pkg::ACC_W-1:0]   acc_q;
	logic [kle_pkg::MOVE_W-1:0]  move_q;
	logic                        out_v_q;
	kle_pkg::out_word_t          out_q;

	kle_pkg::cell_cmd_t          cmd;
	kle_pkg::scan_t              scan_w [kle_pkg::CLUSTERS+1];
	kle_pkg::cell_stat_t         stat_w [kle_pkg::CLUSTERS];
	kle_pkg::cell_stat_t         cur;

	logic                        acc_in;
	logic                        slot_free;
	logic                        out_ld;
	kle_pkg::out_word_t          out_d;
	logic                        ft_ok;
	logic                        cl_ok;
	logic [kle_pkg::FT_W-1:0]    ft_idx;
	logic                        pc_last;
	logic                        pf_last;
	logic [kle_pkg::PASS_W-1:0]  pass_next;
	logic signed [kle_pkg::VAL_W:0]     dd;
	logic signed [2*kle_pkg::VAL_W+1:0] dprod;
	logic [kle_pkg::MOVE_W:0]    msum;
	logic                        div_start;
	logic                        div_done;
	logic [kle_pkg::VAL_W-1:0]   div_q;
	logic                        root_start;
	logic                        root_done;
	logic [kle_pkg::ROOT_W-1:0]  root_w;

	assign req.ready = (state_q == kle_pkg::ST_IDLE);
	assign cfg.ready = 1'b1;
	assign acc_in    = req.valid && req.ready;
	assign slot_free = !out_v_q || rsp.ready;
	assign ft_ok     = (32'(req.data.feature_sel) < kle_pkg::FEATURES);
	assign cl_ok     = (32'(req.data.cluster_sel) < kle_pkg::CLUSTERS);
	assign ft_idx    = kle_pkg::FT_W'(req.data.feature_sel);
	assign cur       = stat_w[pc_q];
	assign pc_last   = (pc_q == kle_pkg::CL_W'(kle_pkg::CLUSTERS - 1));
	assign pf_last   = (pf_q == kle_pkg::FT_W'(kle_pkg::FEATURES - 1));
	assign pass_next = (pass_q == '1) ? pass_q : pass_q + 1'b1;
	assign dd = $signed({cur.cent[pf_q][kle_pkg::VAL_W-1], cur.cent[pf_q]})
		- $signed({nv_q[kle_pkg::VAL_W-1], nv_q});
	assign dprod = dd * dd;
	assign msum  = {1'b0, move_q} + (kle_pkg::MOVE_W + 1)'(root_w);
	assign div_start  = (state_q == kle_pkg::ST_DIV_GO);
	assign root_start = (state_q == kle_pkg::ST_ROOT_GO);

	// head of the cell row: a sentinel above any distance
	assign scan_w[0].valid = (state_q == kle_pkg::ST_SCAN_GO);
	assign scan_w[0].dval  = {1'b1, {kle_pkg::DIST_W{1'b0}}};
	assign scan_w[0].idx   = '0;

	for (genvar c = 0; c < kle_pkg::CLUSTERS; c++) begin : g_cell
		kle_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cl_idx (kle_pkg::CL_W'(c)),
			.cmd    (cmd),
			.scan_i (scan_w[c]),
			.scan_o (scan_w[c+1]),
			.stat   (stat_w[c])
		);
	end

	kle_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cur.sum[pf_q]),
		.divisor  (cur.cnt),
		.done     (div_done),
		.quotient (div_q)
	);

	kle_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.x      (acc_q),
		.done   (root_done),
		.root   (root_w)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kle_pkg::ST_IDLE: begin
				if (acc_in) begin
					case (req.data.opcode)
						kle_pkg::OP_TRAIN, kle_pkg::OP_CLASSIFY: state_d = kle_pkg::ST_ELEM;
						kle_pkg::OP_PASS: state_d = kle_pkg::ST_PASS_CL;
						default: state_d = kle_pkg::ST_IDLE;
					endcase
				end
			end
			kle_pkg::ST_ELEM: state_d = last_q ? kle_pkg::ST_SCAN_GO : kle_pkg::ST_IDLE;
			kle_pkg::ST_SCAN_GO: state_d = kle_pkg::ST_SCAN;
			kle_pkg::ST_SCAN: begin
				if (scan_w[kle_pkg::CLUSTERS].valid) state_d = kle_pkg::ST_RESOLVE;
			end
			kle_pkg::ST_RESOLVE: begin
				if (op_q == kle_pkg::OP_TRAIN || slot_free) state_d = kle_pkg::ST_IDLE;
			end
			kle_pkg::ST_PASS_CL: begin
				if (cur.cnt != '0) state_d = kle_pkg::ST_DIV_GO;
				else if (pc_last) state_d = kle_pkg::ST_REPORT;
			end
			kle_pkg::ST_DIV_GO: state_d = kle_pkg::ST_DIV;
			kle_pkg::ST_DIV: begin
				if (div_done) state_d = kle_pkg::ST_DIFF;
			end
			kle_pkg::ST_DIFF: state_d = kle_pkg::ST_ACC;
			kle_pkg::ST_ACC: state_d = pf_last ? kle_pkg::ST_ROOT_GO : kle_pkg::ST_DIV_GO;
			kle_pkg::ST_ROOT_GO: state_d = kle_pkg::ST_ROOT;
			kle_pkg::ST_ROOT: begin
				if (root_done) state_d = pc_last ? kle_pkg::ST_REPORT : kle_pkg::ST_PASS_CL;
			end
			kle_pkg::ST_REPORT: begin
				if (slot_free) state_d = kle_pkg::ST_IDLE;
			end
			default: state_d = kle_pkg::ST_IDLE;
		endcase
	end

	// cell commands and result word
	always_comb begin
		cmd    = '0;
		cmd.pt = buf_q;
		out_ld = 1'b0;
		out_d  = '0;
		case (state_q)
			kle_pkg::ST_IDLE: begin
				cmd.cl  = kle_pkg::CL_W'(req.data.cluster_sel);
				cmd.ft  = ft_idx;
				cmd.val = req.data.value;
				if (acc_in && ft_ok) begin
					if (req.data.opcode == kle_pkg::OP_LOAD) cmd.cent_wr = cl_ok;
					if (req.data.opcode == kle_pkg::OP_TRAIN
						|| req.data.opcode == kle_pkg::OP_CLASSIFY) cmd.elem = 1'b1;
				end
			end
			kle_pkg::ST_RESOLVE: begin
				cmd.cl = best_idx_q;
				if (op_q == kle_pkg::OP_TRAIN) begin
					cmd.add_pt = 1'b1;
					cmd.clr_pt = 1'b1;
				end else if (slot_free) begin
					cmd.clr_pt    = 1'b1;
					out_ld        = 1'b1;
					out_d.nearest = 3'(best_idx_q);
					out_d.matched = (best_dist_q < reject_q);
				end
			end
			kle_pkg::ST_DIFF: begin
				cmd.cent_wr = 1'b1;
				cmd.cl      = pc_q;
				cmd.ft      = pf_q;
				cmd.val     = nv_q;
			end
			kle_pkg::ST_REPORT: begin
				if (slot_free) begin
					cmd.clr_acc       = 1'b1;
					out_ld            = 1'b1;
					out_d.kind        = 1'b1;
					out_d.movement    = move_q;
					out_d.pass_number = pass_next;
					out_d.finished    = (move_q == '0) || (pass_next > max_passes_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kle_pkg::ST_IDLE;
			max_passes_q <= kle_pkg::MAX_PASSES_RST;
			reject_q     <= '1;
			pass_q       <= '0;
			buf_q        <= '0;
			out_v_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.data.index)
					kle_pkg::CFG_MAX_PASSES: max_passes_q <= cfg.data.value[kle_pkg::PASS_W-1:0];
					kle_pkg::CFG_REJECT:     reject_q <= cfg.data.value[kle_pkg::DIST_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.elem) begin
				buf_q[ft_idx] <= req.data.value;
			end else if (cmd.clr_pt) begin
				buf_q <= '0;
			end
			if (cmd.clr_acc) pass_q <= pass_next;
			if (out_ld) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) out_q <= out_d;
		if (acc_in) begin
			op_q   <= req.data.opcode;
			last_q <= req.data.point_last;
			pc_q   <= '0;
			move_q <= '0;
		end
		if (state_q == kle_pkg::ST_SCAN && scan_w[kle_pkg::CLUSTERS].valid) begin
			best_idx_q  <= scan_w[kle_pkg::CLUSTERS].idx;
			best_dist_q <= scan_w[kle_pkg::CLUSTERS].dval[kle_pkg::DIST_W-1:0];
		end
		if (state_q == kle_pkg::ST_PASS_CL) begin
			acc_q <= '0;
			pf_q  <= '0;
			if (cur.cnt == '0 && !pc_last) pc_q <= pc_q + 1'b1;
		end
		if (state_q == kle_pkg::ST_DIV && div_done) nv_q <= div_q;
		if (state_q == kle_pkg::ST_DIFF) sqd_s1 <= dprod[kle_pkg::SQE_W-1:0];
		if (state_q == kle_pkg::ST_ACC) begin
			acc_q <= acc_q + kle_pkg::ACC_W'(sqd_s1);
			if (!pf_last) pf_q <= pf_q + 1'b1;
		end
		if (state_q == kle_pkg::ST_ROOT && root_done) begin
			move_q <= msum[kle_pkg::MOVE_W] ? '1 : msum[kle_pkg::MOVE_W-1:0];
			if (!pc_last) pc_q <= pc_q + 1'b1;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

`ifndef ASSERT_OFF
	a_scan_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_w[kle_pkg::CLUSTERS].valid |-> state_q == kle_pkg::ST_SCAN)
		else $error("nearest token left the cell row outside the scan");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == kle_pkg::ST_DIV)
		else $error("divider finished outside the divide step");
	a_root_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == kle_pkg::ST_ROOT)
		else $error("root unit finished outside the root step");
	a_still_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.kind && out_q.movement == '0 |-> out_q.finished)
		else $error("pass report with no movement not marked finished");
`endif

endmodule

`default_nettype wire

// ===== test/kle_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kle_checker: k-means engine scoreboard
// Watches the request, response and register channels, keeps its own copy of
// centroids, sums, counts and distances, and checks every response word.
// ----------------------------------------------------------------------------
`default_nettype none

module kle_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	kle_in_if.sink    req,
	kle_out_if.sink   rsp,
	kle_cfg_if.sink   cfg,
	output int        errors,
	output int        pending
);

	localparam logic [35:0] DIST_CAP = 36'hF_FFFF_FFFF;
	localparam logic [21:0] MOVE_CAP = 22'h3F_FFFF;
	localparam longint COUNT_CAP = (64'd1 << kle_pkg::COUNT_BITS) - 1;

	logic [15:0]        pass_limit;
	logic [35:0]        reject_dist;
	logic signed [15:0] cent [kle_pkg::CLUSTERS][kle_pkg::FEATURES];
	longint             sums [kle_pkg::CLUSTERS][kle_pkg::FEATURES];
	longint             members [kle_pkg::CLUSTERS];
	logic [35:0]        part_dist [kle_pkg::CLUSTERS];
	logic signed [15:0] pt [kle_pkg::FEATURES];
	logic [15:0]        passes;
	kle_pkg::out_word_t expected_q[$];

	function automatic longint unsigned sq_diff(longint a, longint b);
		longint d;
		d = a - b;
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic longint unsigned int_root(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic clear_point();
		for (int c = 0; c < kle_pkg::CLUSTERS; c++) part_dist[c] = '0;
		for (int f = 0; f < kle_pkg::FEATURES; f++) pt[f] = '0;
	endtask

	task automatic predict_word(input kle_pkg::in_word_t w);
		kle_pkg::out_word_t o;
		longint unsigned mv, sq, s;
		int best;
		o = '0;
		case (w.opcode)
			kle_pkg::OP_LOAD: cent[w.cluster_sel][w.feature_sel] = w.value;
			kle_pkg::OP_PASS: begin
				mv = 0;
				for (int c = 0; c < kle_pkg::CLUSTERS; c++) begin
					sq = 0;
					if (members[c] != 0)
						for (int f = 0; f < kle_pkg::FEATURES; f++) begin
							longint nv;
							nv = sums[c][f] / members[c];
							sq += sq_diff(cent[c][f], nv);
							cent[c][f] = 16'(nv);
						end
					mv += int_root(sq);
					if (mv > MOVE_CAP) mv = MOVE_CAP;
				end
				for (int c = 0; c < kle_pkg::CLUSTERS; c++) begin
					members[c] = 0;
					for (int f = 0; f < kle_pkg::FEATURES; f++) sums[c][f] = 0;
				end
				if (passes != 16'hFFFF) passes++;
				o.kind = 1'b1;
				o.movement = mv[21:0];
				o.pass_number = passes;
				o.finished = (mv == 0) || (passes > pass_limit);
				expected_q = {expected_q, o};
			end
			default: begin
				pt[w.feature_sel] = w.value;
				for (int c = 0; c < kle_pkg::CLUSTERS; c++) begin
					s = part_dist[c] + sq_diff(w.value, cent[c][w.feature_sel]);
					part_dist[c] = (s > DIST_CAP) ? DIST_CAP : s[35:0];
				end
				if (w.point_last) begin
					best = 0;
					for (int c = 1; c < kle_pkg::CLUSTERS; c++)
						if (part_dist[c] < part_dist[best]) best = c;
					if (w.opcode == kle_pkg::OP_TRAIN) begin
						if (members[best] < COUNT_CAP) begin
							for (int f = 0; f < kle_pkg::FEATURES; f++) sums[best][f] += pt[f];
							members[best]++;
						end
					end else begin
						o.nearest = 3'(best);
						o.matched = part_dist[best] < reject_dist;
						expected_q = {expected_q, o};
					end
					clear_point();
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_limit = kle_pkg::MAX_PASSES_RST;
			reject_dist = DIST_CAP;
			passes = '0;
			for (int c = 0; c < kle_pkg::CLUSTERS; c++) begin
				members[c] = 0;
				for (int f = 0; f < kle_pkg::FEATURES; f++) begin
					cent[c][f] = '0;
					sums[c][f] = 0;
				end
			end
			clear_point();
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.data.index == kle_pkg::CFG_MAX_PASSES) pass_limit = cfg.data.value[15:0];
				else reject_dist = cfg.data.value;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected response word %p", rsp.data);
					errors++;
				end else begin
					kle_pkg::out_word_t e;
					e = expected_q.pop_front();
					if (e.kind !== rsp.data.kind) begin
						$error("kind exp %0d got %0d", e.kind, rsp.data.kind); errors++;
					end
					if (e.nearest !== rsp.data.nearest) begin
						$error("nearest exp %0d got %0d", e.nearest, rsp.data.nearest); errors++;
					end
					if (e.matched !== rsp.data.matched) begin
						$error("matched exp %0d got %0d", e.matched, rsp.data.matched); errors++;
					end
					if (e.movement !== rsp.data.movement) begin
						$error("movement exp %0d got %0d", e.movement, rsp.data.movement);
						errors++;
					end
					if (e.pass_number !== rsp.data.pass_number) begin
						$error("pass_number exp %0d got %0d", e.pass_number,
							rsp.data.pass_number);
						errors++;
					end
					if (e.finished !== rsp.data.finished) begin
						$error("finished exp %0d got %0d", e.finished, rsp.data.finished);
						errors++;
					end
				end
			end
			if (req.valid && req.ready) predict_word(req.data);
		end
		pending = expected_q.size();
	end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: k-means engine test
// Loads centroids, streams training passes and classify points with random
// handshake gaps and register settings; the checker scores every word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending;
	int   src_idle = 9, snk_idle = 61;
	bit   hold_off = 1'b0;
	int   quiet = 0;

	kle_in_if  req ();
	kle_out_if rsp ();
	kle_cfg_if cfg ();

	kmeans_lloyd_engine_unit i_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg));
	kle_checker i_checker (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cfg(cfg),
		.errors(errors), .pending(pending));

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		req.valid = 1'b0; req.data = '0;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0; cfg.data = '0;
	end

	// receiver side stalls
	always @(posedge clk) begin
		if (hold_off) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(99) >= snk_idle);
	end

	// watchdog on accepted words
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
			quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// valid stays high after an accept so the next word can follow at once
	task automatic send_word(input kle_pkg::op_t op, input int cl, input int ft,
		input logic [15:0] v, input bit last);
		kle_pkg::in_word_t w;
		w.opcode = op; w.cluster_sel = 3'(cl); w.feature_sel = 2'(ft);
		w.value = v; w.point_last = last;
		while ($urandom_range(99) < src_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= w;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic idle_req();
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [35:0] v);
		cfg.valid <= 1'b1;
		cfg.data <= {idx, v};
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [15:0] rnd_val(input bit narrow);
		if (narrow) return 16'($urandom_range(2047) - 1024);
		return 16'($urandom);
	endfunction

	task automatic send_point(input kle_pkg::op_t op, input bit narrow);
		for (int f = 0; f < kle_pkg::FEATURES; f++)
			send_word(op, 0, f, rnd_val(narrow), f == kle_pkg::FEATURES - 1);
	endtask

	task automatic run_phase(input int n);
		int k;
		k = 0;
		while (k < n) begin
			int r;
			r = $urandom_range(99);
			if (r < 8) begin
				send_word(kle_pkg::OP_LOAD, $urandom_range(7), $urandom_range(3),
					rnd_val(1'($urandom_range(1))), 1'($urandom_range(1)));
				k++;
			end else if (r < 50) begin
				send_point(kle_pkg::OP_TRAIN, $urandom_range(3) != 0);
				k += kle_pkg::FEATURES;
			end else if (r < 75) begin
				send_point(kle_pkg::OP_CLASSIFY, $urandom_range(3) != 0);
				k += kle_pkg::FEATURES;
			end else if (r < 82) begin
				send_word(kle_pkg::OP_PASS, $urandom_range(7), $urandom_range(3),
					16'($urandom), 1'($urandom_range(1)));
				k++;
			end else begin
				// broken or mixed element
				send_word(kle_pkg::op_t'($urandom_range(1) ? kle_pkg::OP_TRAIN
					: kle_pkg::OP_CLASSIFY), $urandom_range(7), $urandom_range(3),
					16'($urandom), 1'($urandom_range(1)));
				k++;
			end
		end
		idle_req();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, special cases
		write_reg(kle_pkg::CFG_MAX_PASSES, 36'd1);
		send_word(kle_pkg::OP_PASS, 0, 0, 16'h0000, 1'b1);     // all clusters empty
		send_word(kle_pkg::OP_LOAD, 7, 3, 16'h7FFF, 1'b1);
		send_word(kle_pkg::OP_LOAD, 0, 0, 16'h8000, 1'b0);
		send_word(kle_pkg::OP_CLASSIFY, 0, 0, 16'h7FFF, 1'b0);
		send_word(kle_pkg::OP_CLASSIFY, 0, 0, 16'h7FFF, 1'b0); // repeated feature
		send_word(kle_pkg::OP_CLASSIFY, 3, 3, 16'h8000, 1'b1);
		send_word(kle_pkg::OP_TRAIN, 0, 1, 16'h0100, 1'b0);
		send_word(kle_pkg::OP_CLASSIFY, 0, 2, 16'hFF00, 1'b0); // mixed point, train decides
		send_word(kle_pkg::OP_TRAIN, 0, 3, 16'h8000, 1'b1);
		send_word(kle_pkg::OP_TRAIN, 0, 0, 16'h7FFF, 1'b1);
		send_word(kle_pkg::OP_TRAIN, 0, 2, 16'hFFFF, 1'b0);    // unfinished across pass
		send_word(kle_pkg::OP_PASS, 0, 0, 16'h0000, 1'b0);
		send_word(kle_pkg::OP_TRAIN, 0, 1, 16'h0001, 1'b1);
		send_word(kle_pkg::OP_PASS, 0, 0, 16'h0000, 1'b0);     // exceeds pass limit
		send_word(kle_pkg::OP_PASS, 0, 0, 16'h0000, 1'b0);
		for (int i = 0; i < 4; i++)
			send_word(kle_pkg::OP_CLASSIFY, 0, i, 16'h8000, i == 3);
		idle_req();
		drain();

		write_reg(kle_pkg::CFG_REJECT, 36'd0);
		write_reg(kle_pkg::CFG_MAX_PASSES, 36'hFFFF);
		send_point(kle_pkg::OP_CLASSIFY, 1'b0);
		idle_req();
		drain();
		write_reg(kle_pkg::CFG_REJECT, 36'h0_0010_0000);
		write_reg(kle_pkg::CFG_MAX_PASSES, 36'd0);
		run_phase(500);
		drain();

		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			run_phase(60);
		join
		drain();

		src_idle = 61; snk_idle = 9;
		write_reg(kle_pkg::CFG_REJECT, 36'hF_FFFF_FFFF);
		write_reg(kle_pkg::CFG_MAX_PASSES, 36'd5);
		run_phase(500);
		drain();

		src_idle = 0; snk_idle = 0;
		write_reg(kle_pkg::CFG_REJECT, 36'({$urandom_range(15), $urandom}));
		write_reg(kle_pkg::CFG_MAX_PASSES, 36'($urandom_range(65535)));
		run_phase(500);
		drain();

		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
